// File: rtl/circuit_slot_table_macros.svh
// Assertion macros for the circuit slot table.
// Included by the modules that check their own logic; empty for synthesis.
`ifndef CIRCUIT_SLOT_TABLE_MACROS_SVH
`define CIRCUIT_SLOT_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define CST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define CST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/cst_pkg.sv
// Shared constants, types and helpers for the circuit slot table.
// No dependencies; used by the interfaces and every module.
package cst_pkg;

    localparam int NUM_CIRCUITS = 32;
    localparam int SLOT_W       = (NUM_CIRCUITS > 1) ? $clog2(NUM_CIRCUITS) : 1;
    localparam int CNT_W        = $clog2(NUM_CIRCUITS + 1);
    localparam int FUNC_W       = 2;
    localparam int IDX_W        = 8;
    localparam int ID_W         = 8;
    localparam int ADDR_W       = 56;
    localparam int OUT_SLOT_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC    = 2'd0,
        FUNC_FREE     = 2'd1,
        FUNC_VALIDATE = 2'd2,
        FUNC_MATCH    = 2'd3
    } t_func;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] user;
        logic [ADDR_W-1:0] node;
    } t_remote;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_remote           wdata;
        logic [SLOT_W-1:0] raddr;
    } t_mem_req;

    // The reported slot number is the slot taken modulo 32.
    function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input logic [SLOT_W-1:0] slot);
        logic [7:0] wide;
        wide = 8'(slot);
        return wide[OUT_SLOT_W-1:0];
    endfunction

endpackage

// File: rtl/cst_if.sv
// Valid/ready channel interfaces for requests and results of the slot table.
// Depends on cst_pkg for the field widths.
interface cst_in_if;
    logic                        valid;
    logic                        ready;
    logic [cst_pkg::FUNC_W-1:0]  func;
    logic [cst_pkg::IDX_W-1:0]   circuit_index;
    logic [cst_pkg::ID_W-1:0]    circuit_id;
    logic [cst_pkg::ADDR_W-1:0]  user_address;
    logic [cst_pkg::ADDR_W-1:0]  node_address;

    modport source (
        output valid, func, circuit_index, circuit_id, user_address, node_address,
        input  ready
    );
    modport sink (
        input  valid, func, circuit_index, circuit_id, user_address, node_address,
        output ready
    );
endinterface

interface cst_out_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [cst_pkg::OUT_SLOT_W-1:0] slot_index;
    logic [cst_pkg::ID_W-1:0]       slot_id;

    modport source (
        output valid, hit, slot_index, slot_id,
        input  ready
    );
    modport sink (
        input  valid, hit, slot_index, slot_id,
        output ready
    );
endinterface

// File: rtl/cst_store.sv
// Remote-field memory of the slot table: one write port, one registered read port.
// Depends on cst_pkg for the entry and request types.
module cst_store (
    input  logic              i_clk,
    input  cst_pkg::t_mem_req i_req,
    output cst_pkg::t_remote  o_q
);

    cst_pkg::t_remote r_mem [cst_pkg::NUM_CIRCUITS];
    cst_pkg::t_remote r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_q <= r_mem[i_req.raddr];
    end

    assign o_q = r_q;

endmodule

// File: rtl/cst_ctrl.sv
// Sequencer of the slot table: valid marks, generation ids, slot scan and result register.
// Depends on cst_pkg, the channel interfaces and the assertion macro header.
`include "circuit_slot_table_macros.svh"

module cst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cst_in_if.sink            i_req,
    cst_out_if.source         o_rsp,
    output cst_pkg::t_mem_req o_mem_req,
    input  cst_pkg::t_remote  i_mem_q
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_LOCAL,
        ST_MATCH,
        ST_EMIT
    } t_state;

    t_state                            r_state, n_state;
    cst_pkg::t_func                    r_func, n_func;
    cst_pkg::t_remote                  r_key, n_key;
    logic [cst_pkg::CNT_W-1:0]         r_slot, n_slot;
    logic [cst_pkg::SLOT_W-1:0]        r_cmp_slot, n_cmp_slot;
    logic                              r_pend, n_pend;
    logic [cst_pkg::NUM_CIRCUITS-1:0]  r_valid, n_valid;
    logic [cst_pkg::ID_W-1:0]          r_gen [cst_pkg::NUM_CIRCUITS];
    logic                              r_res_hit, n_res_hit;
    logic [cst_pkg::SLOT_W-1:0]        r_res_slot, n_res_slot;
    logic [cst_pkg::ID_W-1:0]          r_res_id, n_res_id;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_hit, n_out_hit;
    logic [cst_pkg::OUT_SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic [cst_pkg::ID_W-1:0]          r_out_id, n_out_id;

    logic                       gen_we;
    logic [cst_pkg::SLOT_W-1:0] gen_wslot;
    logic [cst_pkg::ID_W-1:0]   gen_wval;
    logic [cst_pkg::SLOT_W-1:0] scan_slot;
    logic [cst_pkg::SLOT_W-1:0] loc_slot;
    logic                       in_range;
    logic                       key_eq;
    logic                       out_free;

    assign scan_slot = r_slot[cst_pkg::SLOT_W-1:0];
    assign loc_slot  = r_key.idx[cst_pkg::SLOT_W-1:0];
    assign in_range  = (r_key.idx < cst_pkg::IDX_W'(cst_pkg::NUM_CIRCUITS));
    assign key_eq    = (i_mem_q == r_key);
    assign out_free  = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_slot      = r_slot;
        n_cmp_slot  = r_cmp_slot;
        n_pend      = r_pend;
        n_valid     = r_valid;
        n_res_hit   = r_res_hit;
        n_res_slot  = r_res_slot;
        n_res_id    = r_res_id;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_slot  = r_out_slot;
        n_out_id    = r_out_id;
        gen_we      = 1'b0;
        gen_wslot   = loc_slot;
        gen_wval    = r_gen[loc_slot] + 1'b1;
        o_mem_req       = '0;
        o_mem_req.raddr = scan_slot;
        o_mem_req.waddr = scan_slot;
        o_mem_req.wdata = r_key;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_func     = cst_pkg::t_func'(i_req.func);
                    n_key.idx  = i_req.circuit_index;
                    n_key.id   = i_req.circuit_id;
                    n_key.user = i_req.user_address;
                    n_key.node = i_req.node_address;
                    n_slot     = '0;
                    n_pend     = 1'b0;
                    unique case (cst_pkg::t_func'(i_req.func))
                        cst_pkg::FUNC_ALLOC: n_state = ST_ALLOC;
                        cst_pkg::FUNC_MATCH: n_state = ST_MATCH;
                        default:             n_state = ST_LOCAL;
                    endcase
                end
            end
            ST_ALLOC: begin
                if (!r_valid[scan_slot]) begin
                    o_mem_req.we       = 1'b1;
                    n_valid[scan_slot] = 1'b1;
                    n_res_hit          = 1'b1;
                    n_res_slot         = scan_slot;
                    n_res_id           = r_gen[scan_slot];
                    n_state            = ST_EMIT;
                end else if (r_slot == cst_pkg::CNT_W'(cst_pkg::NUM_CIRCUITS - 1)) begin
                    n_res_hit  = 1'b0;
                    n_res_slot = '0;
                    n_res_id   = '0;
                    n_state    = ST_EMIT;
                end else begin
                    n_slot = cst_pkg::CNT_W'(r_slot + 1'b1);
                end
            end
            ST_LOCAL: begin
                n_res_hit  = 1'b0;
                n_res_slot = '0;
                n_res_id   = '0;
                if (in_range && r_valid[loc_slot]) begin
                    if (r_func == cst_pkg::FUNC_FREE) begin
                        gen_we            = 1'b1;
                        n_valid[loc_slot] = 1'b0;
                        n_res_hit         = 1'b1;
                        n_res_slot        = loc_slot;
                        n_res_id          = gen_wval;
                    end else if (r_gen[loc_slot] == r_key.id) begin
                        n_res_hit  = 1'b1;
                        n_res_slot = loc_slot;
                        n_res_id   = r_gen[loc_slot];
                    end
                end
                n_state = ST_EMIT;
            end
            ST_MATCH: begin
                // The memory read data arrives in the cycle after the scan address is presented.
                if (r_pend && r_valid[r_cmp_slot] && key_eq) begin
                    n_res_hit  = 1'b1;
                    n_res_slot = r_cmp_slot;
                    n_res_id   = r_gen[r_cmp_slot];
                    n_state    = ST_EMIT;
                end else if (r_pend &&
                             r_cmp_slot == cst_pkg::SLOT_W'(cst_pkg::NUM_CIRCUITS - 1)) begin
                    n_res_hit  = 1'b0;
                    n_res_slot = '0;
                    n_res_id   = '0;
                    n_state    = ST_EMIT;
                end else begin
                    n_cmp_slot = scan_slot;
                    n_pend     = 1'b1;
                    n_slot     = cst_pkg::CNT_W'(r_slot + 1'b1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_slot  = cst_pkg::to_out_slot(r_res_slot);
                    n_out_id    = r_res_id;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_slot     <= n_slot;
        r_cmp_slot <= n_cmp_slot;
        r_pend     <= n_pend;
        r_res_hit  <= n_res_hit;
        r_res_slot <= n_res_slot;
        r_res_id   <= n_res_id;
        r_out_hit  <= n_out_hit;
        r_out_slot <= n_out_slot;
        r_out_id   <= n_out_id;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_gen       <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            if (gen_we) begin
                r_gen[gen_wslot] <= gen_wval;
            end
        end
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.slot_index = r_out_slot;
    assign o_rsp.slot_id    = r_out_id;

    `CST_ASSERT_IMPL(a_alloc_into_free_slot, i_clk, i_rst_n, o_mem_req.we, !r_valid[o_mem_req.waddr])
    `CST_ASSERT_IMPL(a_free_clears_mark, i_clk, i_rst_n, r_state == ST_EMIT && r_res_hit && r_func == cst_pkg::FUNC_FREE, !r_valid[r_res_slot])
    `CST_ASSERT_IMPL(a_hit_slot_in_use, i_clk, i_rst_n, r_state == ST_EMIT && r_res_hit && r_func != cst_pkg::FUNC_FREE, r_valid[r_res_slot])
    `CST_ASSERT_NEXT(a_free_bumps_id, i_clk, i_rst_n, r_state == ST_LOCAL && gen_we, r_gen[r_res_slot] == r_res_id)
    `CST_ASSERT_IMPL(a_miss_is_zero, i_clk, i_rst_n, r_out_valid && !r_out_hit, r_out_slot == '0 && r_out_id == '0)

endmodule

// File: rtl/circuit_slot_table.sv
// Top level of the circuit slot table: request and result channels around
// the sequencer (cst_ctrl) and the remote-field memory (cst_store). Depends on cst_pkg.
//
// Use: a request transfer on i_req carries func (allocate, free, validate,
// match), a circuit index and id, and the user and node addresses. Each request
// yields exactly one result transfer on o_rsp with hit, slot_index and slot_id.
// One request is worked on at a time; i_req.ready is high only while idle.
// Free and validate look only at the slot named by the circuit index; allocate
// stops at the lowest free slot and match at the lowest matching slot, and both
// go through all NUM_CIRCUITS slots when none is found. Allocate scans the valid
// marks and match scans the remote-field memory through its single read port,
// one slot per cycle.
// Reset clears all valid marks and generation ids at once; no clearing pass.
// The result sits in an output register; a new request is taken while it
// waits, and if the receiver stalls the next result is held until it is taken.
module circuit_slot_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cst_in_if.sink    i_req,
    cst_out_if.source o_rsp
);

    cst_pkg::t_mem_req mem_req;
    cst_pkg::t_remote  mem_q;

    cst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem_req (mem_req),
        .i_mem_q   (mem_q)
    );

    cst_store u_store (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_q   (mem_q)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for circuit_slot_table: directed and random requests with a
// built-in slot table predictor. Depends on cst_pkg, cst_in_if, cst_out_if and the RTL.
module tb_top;
    import cst_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic                  hit;
        logic [OUT_SLOT_W-1:0] slot;
        logic [ID_W-1:0]       gen;
    } outcome_t;

    logic i_clk;
    logic i_rst_n;

    cst_in_if  req_if ();
    cst_out_if rsp_if ();

    circuit_slot_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic              slot_live    [NUM_CIRCUITS];
    logic [ID_W-1:0]   slot_gen     [NUM_CIRCUITS];
    logic [IDX_W-1:0]  remote_index [NUM_CIRCUITS];
    logic [ID_W-1:0]   remote_id    [NUM_CIRCUITS];
    logic [ADDR_W-1:0] remote_user  [NUM_CIRCUITS];
    logic [ADDR_W-1:0] remote_node  [NUM_CIRCUITS];

    outcome_t pending_results[$];
    int       mismatch_count  = 0;
    int       hold_off_cycles = 0;
    bit       quiet_mode      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_live_slot();
        int candidates[$];
        for (int s = 0; s < NUM_CIRCUITS; s++) begin
            if (slot_live[s]) candidates.push_back(s);
        end
        if (candidates.size() == 0) return -1;
        return candidates[$urandom_range(0, candidates.size() - 1)];
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int s = 0; s < NUM_CIRCUITS; s++) n += int'(slot_live[s]);
        return n;
    endfunction

    // Applies one request to the predicted table and returns the result it should give.
    function automatic outcome_t apply_table_op(input t_func f, input logic [IDX_W-1:0] cidx,
                                                input logic [ID_W-1:0] cid,
                                                input logic [ADDR_W-1:0] user,
                                                input logic [ADDR_W-1:0] node);
        outcome_t o;
        o = '0;
        case (f)
            FUNC_ALLOC: begin
                for (int s = 0; s < NUM_CIRCUITS && !o.hit; s++) begin
                    if (!slot_live[s]) begin
                        slot_live[s]    = 1'b1;
                        remote_index[s] = cidx;
                        remote_id[s]    = cid;
                        remote_user[s]  = user;
                        remote_node[s]  = node;
                        o.hit  = 1'b1;
                        o.slot = OUT_SLOT_W'(s);
                        o.gen  = slot_gen[s];
                    end
                end
            end
            FUNC_FREE: begin
                if (cidx < NUM_CIRCUITS && slot_live[cidx]) begin
                    slot_live[cidx] = 1'b0;
                    slot_gen[cidx]  = slot_gen[cidx] + 1'b1;
                    o.hit  = 1'b1;
                    o.slot = OUT_SLOT_W'(cidx);
                    o.gen  = slot_gen[cidx];
                end
            end
            FUNC_VALIDATE: begin
                if (cidx < NUM_CIRCUITS && slot_live[cidx] && slot_gen[cidx] == cid) begin
                    o.hit  = 1'b1;
                    o.slot = OUT_SLOT_W'(cidx);
                    o.gen  = slot_gen[cidx];
                end
            end
            default: begin
                for (int s = 0; s < NUM_CIRCUITS && !o.hit; s++) begin
                    if (slot_live[s] && remote_index[s] == cidx && remote_id[s] == cid &&
                        remote_user[s] == user && remote_node[s] == node) begin
                        o.hit  = 1'b1;
                        o.slot = OUT_SLOT_W'(s);
                        o.gen  = slot_gen[s];
                    end
                end
            end
        endcase
        return o;
    endfunction

    task automatic send_request(input t_func f, input logic [IDX_W-1:0] cidx,
                                input logic [ID_W-1:0] cid,
                                input logic [ADDR_W-1:0] user,
                                input logic [ADDR_W-1:0] node);
        int gap;
        gap = quiet_mode ? 0 : draw_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.valid         = 1'b1;
        req_if.func          = f;
        req_if.circuit_index = cidx;
        req_if.circuit_id    = cid;
        req_if.user_address  = user;
        req_if.node_address  = node;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(apply_table_op(f, cidx, cid, user, node));
    endtask

    task automatic alloc_random();
        send_request(FUNC_ALLOC, rand_byte(), rand_byte(), rand_addr(), rand_addr());
    endtask

    task automatic fill_table();
        while (live_count() < NUM_CIRCUITS) alloc_random();
    endtask

    task automatic test_empty_table();
        send_request(FUNC_VALIDATE, 8'd0, 8'd0, '0, '0);
        send_request(FUNC_FREE, 8'd0, 8'd0, '0, '0);
        send_request(FUNC_FREE, 8'd255, 8'd255, '1, '1);
        send_request(FUNC_VALIDATE, 8'd255, 8'd255, '1, '1);
    endtask

    task automatic test_field_extremes();
        send_request(FUNC_ALLOC, 8'd255, 8'd255, '1, '1);
        send_request(FUNC_ALLOC, 8'd0, 8'd0, '0, '0);
        send_request(FUNC_VALIDATE, 8'd1, 8'd0, '0, '0);
        send_request(FUNC_VALIDATE, 8'd1, 8'd255, '0, '0);
        send_request(FUNC_VALIDATE, 8'd31, 8'd0, '0, '0);
    endtask

    task automatic test_free_generation();
        send_request(FUNC_FREE, 8'd1, 8'd0, '0, '0);
        send_request(FUNC_FREE, 8'd1, 8'd0, '0, '0);
        send_request(FUNC_VALIDATE, 8'd1, 8'd1, '0, '0);
        alloc_random();
        send_request(FUNC_VALIDATE, 8'd1, 8'd1, '0, '0);
    endtask

    task automatic test_table_full();
        fill_table();
        alloc_random();
        send_request(FUNC_FREE, 8'(NUM_CIRCUITS), 8'd0, '0, '0);
        send_request(FUNC_VALIDATE, 8'(NUM_CIRCUITS), 8'd0, '0, '0);
        send_request(FUNC_VALIDATE, 8'(NUM_CIRCUITS - 1), slot_gen[NUM_CIRCUITS - 1], '0, '0);
    endtask

    task automatic test_match_rules();
        send_request(FUNC_MATCH, 8'd255, 8'd255, '1, '1);
        send_request(FUNC_MATCH, 8'd254, 8'd255, '1, '1);
        send_request(FUNC_MATCH, 8'd255, 8'd127, '1, '1);
        send_request(FUNC_MATCH, 8'd255, 8'd255, {1'b0, {(ADDR_W-1){1'b1}}}, '1);
        send_request(FUNC_MATCH, 8'd255, 8'd255, '1, {{(ADDR_W-1){1'b1}}, 1'b0});
        // A duplicate in a higher slot is only found once the lower one is gone.
        send_request(FUNC_FREE, 8'd5, 8'd0, '0, '0);
        send_request(FUNC_ALLOC, 8'd255, 8'd255, '1, '1);
        send_request(FUNC_MATCH, 8'd255, 8'd255, '1, '1);
        send_request(FUNC_FREE, 8'd0, 8'd0, '0, '0);
        send_request(FUNC_MATCH, 8'd255, 8'd255, '1, '1);
        alloc_random();
    endtask

    task automatic test_generation_wrap();
        fill_table();
        quiet_mode = ($urandom_range(0, 1) == 0);
        send_request(FUNC_FREE, 8'd9, 8'd0, '0, '0);
        repeat (255) begin
            alloc_random();
            send_request(FUNC_FREE, 8'd9, 8'd0, '0, '0);
        end
        alloc_random();
        send_request(FUNC_VALIDATE, 8'd9, slot_gen[9], '0, '0);
        quiet_mode = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int s;
        hold_off_cycles = HOLD_CYCLES;
        quiet_mode      = 1'b1;
        repeat (30) begin
            s = pick_live_slot();
            if (s < 0) begin
                alloc_random();
            end else if ($urandom_range(0, 1) == 0) begin
                send_request(FUNC_VALIDATE, 8'(s), slot_gen[s], '0, '0);
            end else begin
                send_request(FUNC_MATCH, remote_index[s], remote_id[s], remote_user[s],
                             remote_node[s]);
            end
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items);
        int               pick;
        int               s;
        int               field;
        logic [IDX_W-1:0] a;
        logic [ID_W-1:0]  b;
        logic [ADDR_W-1:0] u;
        logic [ADDR_W-1:0] v;
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            s    = pick_live_slot();
            if (pick < 10 || (s < 0 && pick >= 55)) begin
                send_request(t_func'($urandom_range(0, 3)), rand_byte(), rand_byte(),
                             rand_addr(), rand_addr());
            end else if (pick < 35) begin
                if (s >= 0 && $urandom_range(0, 3) == 0) begin
                    send_request(FUNC_ALLOC, remote_index[s], remote_id[s], remote_user[s],
                                 remote_node[s]);
                end else begin
                    alloc_random();
                end
            end else if (pick < 55) begin
                if (s >= 0 && $urandom_range(0, 4) != 0) begin
                    send_request(FUNC_FREE, 8'(s), rand_byte(), rand_addr(), rand_addr());
                end else begin
                    send_request(FUNC_FREE, rand_byte(), rand_byte(), rand_addr(),
                                 rand_addr());
                end
            end else if (pick < 77) begin
                b = slot_gen[s];
                if ($urandom_range(0, 3) == 0) b = b ^ (8'd1 << $urandom_range(0, 7));
                send_request(FUNC_VALIDATE, 8'(s), b, rand_addr(), rand_addr());
            end else begin
                a = remote_index[s];
                b = remote_id[s];
                u = remote_user[s];
                v = remote_node[s];
                if ($urandom_range(0, 3) == 0) begin
                    field = $urandom_range(0, 3);
                    case (field)
                        0: a = a ^ (8'd1 << $urandom_range(0, 7));
                        1: b = b ^ (8'd1 << $urandom_range(0, 7));
                        2: u = u ^ (56'd1 << $urandom_range(0, ADDR_W - 1));
                        default: v = v ^ (56'd1 << $urandom_range(0, ADDR_W - 1));
                    endcase
                end
                send_request(FUNC_MATCH, a, b, u, v);
            end
        end
        quiet_mode = 1'b0;
    endtask

    // Result receiver: random stalls, plus one long hold-off when requested.
    initial begin
        int n;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
                rsp_if.ready = 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                n = quiet_mode ? 0 : draw_gap();
                rsp_if.ready = (n == 0);
                if (n > 1) repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        outcome_t want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: hit %0d slot_index %0d slot_id %0d",
                       rsp_if.hit, rsp_if.slot_index, rsp_if.slot_id);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.hit !== want.hit) begin
                    $error("hit: expected %0d, actual %0d", want.hit, rsp_if.hit);
                    mismatch_count++;
                end
                if (rsp_if.slot_index !== want.slot) begin
                    $error("slot_index: expected %0d, actual %0d", want.slot,
                           rsp_if.slot_index);
                    mismatch_count++;
                end
                if (rsp_if.slot_id !== want.gen) begin
                    $error("slot_id: expected %0d, actual %0d", want.gen, rsp_if.slot_id);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        for (int s = 0; s < NUM_CIRCUITS; s++) begin
            slot_live[s]    = 1'b0;
            slot_gen[s]     = '0;
            remote_index[s] = '0;
            remote_id[s]    = '0;
            remote_user[s]  = '0;
            remote_node[s]  = '0;
        end
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.func          = FUNC_ALLOC;
        req_if.circuit_index = '0;
        req_if.circuit_id    = '0;
        req_if.user_address  = '0;
        req_if.node_address  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_field_extremes();
        test_free_generation();
        test_table_full();
        test_match_rules();
        test_generation_wrap();
        test_output_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_if.sv
rtl/cst_store.sv
rtl/cst_ctrl.sv
rtl/circuit_slot_table.sv
tb/tb_top.sv
